// ===== rtl/rte_pkg.sv =====
`default_nettype none

package rte_pkg;

    // Register indexes on the configuration port
    localparam logic [1:0] CFG_PREAMBLE_TICKS = 2'd0;
    localparam logic [1:0] CFG_ZERO_TICKS     = 2'd1;
    localparam logic [1:0] CFG_ONE_TICKS      = 2'd2;
    localparam logic [1:0] CFG_REPEAT_COUNT   = 2'd3;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 12;

    localparam logic [11:0] PREAMBLE_TICKS_RST = 12'd525;
    localparam logic [9:0]  ZERO_TICKS_RST     = 10'd150;
    localparam logic [9:0]  ONE_TICKS_RST      = 10'd300;
    localparam logic [7:0]  REPEAT_COUNT_RST   = 8'd150;

    localparam logic [6:0]  KEY_MASK = 7'h7F;

    // Segment being sent
    typedef enum logic [1:0] {
        PH_PREAMBLE = 2'd0,
        PH_BIT      = 2'd1,
        PH_ZERO_INV = 2'd2,
        PH_SPARE    = 2'd3
    } phase_t;

    typedef struct packed {
        logic        start_req;
        logic [15:0] remote_code;
        logic [6:0]  key_id;
    } in_item_t;

    typedef struct packed {
        logic line_level;
        logic busy_res;
    } out_item_t;

    typedef struct packed {
        logic [11:0] preamble_ticks;
        logic [9:0]  zero_ticks;
        logic [9:0]  one_ticks;
        logic [7:0]  repeat_count;
    } cfg_t;

    // Sequencer control state (frame word kept apart, its width is a parameter)
    typedef struct packed {
        logic        active;
        logic        level;
        phase_t      phase;
        logic [11:0] tick_timer;
        logic [4:0]  bit_index;
        logic [7:0]  repeats_left;
    } ctl_t;

endpackage

`default_nettype wire

// ===== rtl/rte_step.sv =====
`default_nettype none

module rte_step #(
    parameter int FRAME_BITS = 23
) (
    input  var rte_pkg::ctl_t     ctl,
    input  var logic [FRAME_BITS-1:0] frame_word,
    input  var rte_pkg::in_item_t item,
    input  var rte_pkg::cfg_t     cfg,
    output rte_pkg::ctl_t         ctl_next,
    output logic [FRAME_BITS-1:0] frame_next,
    output rte_pkg::out_item_t    result
);

    localparam int IDX_W = (FRAME_BITS > 1) ? $clog2(FRAME_BITS) : 1;
    localparam logic [4:0] LAST_BIT = 5'(FRAME_BITS - 1);

    logic [31:0] cmd;
    logic [11:0] pre_dur;
    logic [11:0] zero_dur;
    logic [11:0] one_dur;
    logic [7:0]  rep_init;

    assign cmd      = {9'd0, item.remote_code, item.key_id & rte_pkg::KEY_MASK};
    assign pre_dur  = (cfg.preamble_ticks == 12'd0) ? 12'd1 : cfg.preamble_ticks;
    assign zero_dur = (cfg.zero_ticks == 10'd0) ? 12'd1 : {2'd0, cfg.zero_ticks};
    assign one_dur  = (cfg.one_ticks == 10'd0) ? 12'd1 : {2'd0, cfg.one_ticks};
    assign rep_init = (cfg.repeat_count == 8'd0) ? 8'd1 : cfg.repeat_count;

    always_comb
    begin
        rte_pkg::ctl_t          s;
        logic [FRAME_BITS-1:0]  fw;
        logic                   cur_bit;
        logic [11:0]            dur;
        logic [11:0]            t;
        logic                   step_bit;

        s        = ctl;
        fw       = frame_word;
        step_bit = 1'b0;
        result   = '0;
        ctl_next = ctl;

        // Idle tick with a request: latch the command, this tick is already preamble
        if (!s.active && item.start_req)
        begin
            fw             = cmd[FRAME_BITS-1:0];
            s.active       = 1'b1;
            s.phase        = rte_pkg::PH_PREAMBLE;
            s.tick_timer   = 12'd0;
            s.bit_index    = 5'd0;
            s.repeats_left = rep_init;
        end

        cur_bit = fw[s.bit_index[IDX_W-1:0]];

        case (s.phase)
            rte_pkg::PH_PREAMBLE:
            begin
                result.line_level = 1'b1;
                dur               = pre_dur;
            end
            rte_pkg::PH_BIT:
            begin
                result.line_level = s.level;
                dur               = cur_bit ? one_dur : zero_dur;
            end
            default:
            begin
                result.line_level = ~s.level;
                dur               = zero_dur;
            end
        endcase

        t = s.tick_timer + 12'd1;
        s.tick_timer = t;
        if (t >= dur || t == 12'd0)
        begin
            s.tick_timer = 12'd0;
            case (s.phase)
                rte_pkg::PH_PREAMBLE:
                begin
                    s.level     = 1'b0;
                    s.phase     = rte_pkg::PH_BIT;
                    s.bit_index = LAST_BIT;
                end
                rte_pkg::PH_BIT:
                begin
                    if (cur_bit)
                    begin
                        s.level  = ~s.level;
                        step_bit = 1'b1;
                    end
                    else
                    begin
                        s.phase = rte_pkg::PH_ZERO_INV;
                    end
                end
                default:
                begin
                    step_bit = 1'b1;
                end
            endcase
        end

        // Advance to the next bit, or to the next frame / idle after bit 0
        if (step_bit)
        begin
            if (s.bit_index == 5'd0)
            begin
                s.repeats_left = s.repeats_left - 8'd1;
                s.phase        = rte_pkg::PH_PREAMBLE;
                if (s.repeats_left == 8'd0)
                begin
                    s.active = 1'b0;
                    s.level  = 1'b0;
                end
            end
            else
            begin
                s.bit_index = s.bit_index - 5'd1;
                s.phase     = rte_pkg::PH_BIT;
            end
        end

        result.busy_res = 1'b1;
        frame_next      = fw;

        if (!ctl.active && !item.start_req)
        begin
            // Idle tick, nothing to send
            result     = '0;
            frame_next = frame_word;
        end
        else
        begin
            ctl_next = s;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/rf_remote_toggle_encoder_top.sv =====
// A result item is registered and shown the cycle after its tick is accepted.
// Throughput: 1 item per cycle unless a result is stalled; the single result
//   register is the only stage, and a tick enters as a held result is taken.
// Reset: rst_n clears the sequencer to idle (line low) and loads the timing
//   registers with their defaults; no clearing pass.
`default_nettype none

module rf_remote_toggle_encoder_top #(
    parameter int FRAME_BITS = 23   // command bits sent per frame, 1..32
) (
    input  var logic                            clk,
    input  var logic                            rst_n,
    // tick items in
    input  var logic                            in_valid,
    output logic                                in_stall,
    input  var rte_pkg::in_item_t               in_data,
    // result items out
    output logic                                out_valid,
    input  var logic                            out_stall,
    output rte_pkg::out_item_t                  out_data,
    // configuration writes
    input  var logic                            cfg_we,
    input  var logic [rte_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  var logic [rte_pkg::CFG_DATA_W-1:0]  cfg_data
);

    rte_pkg::cfg_t             cfg_reg;
    rte_pkg::ctl_t             ctl_reg;
    rte_pkg::ctl_t             ctl_next;
    logic [FRAME_BITS-1:0]     frame_reg;
    logic [FRAME_BITS-1:0]     frame_next;
    rte_pkg::out_item_t        out_reg;
    rte_pkg::out_item_t        result;
    logic                      out_valid_reg;
    logic                      in_accept;

    // Input waits only while a finished result is held and downstream stalls.
    assign in_stall  = out_valid_reg & out_stall;
    assign in_accept = in_valid & ~in_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // Timing registers; a mid-sequence write is used from the next tick on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.preamble_ticks <= rte_pkg::PREAMBLE_TICKS_RST;
            cfg_reg.zero_ticks     <= rte_pkg::ZERO_TICKS_RST;
            cfg_reg.one_ticks      <= rte_pkg::ONE_TICKS_RST;
            cfg_reg.repeat_count   <= rte_pkg::REPEAT_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rte_pkg::CFG_PREAMBLE_TICKS: cfg_reg.preamble_ticks <= cfg_data;
                rte_pkg::CFG_ZERO_TICKS:     cfg_reg.zero_ticks     <= cfg_data[9:0];
                rte_pkg::CFG_ONE_TICKS:      cfg_reg.one_ticks      <= cfg_data[9:0];
                rte_pkg::CFG_REPEAT_COUNT:   cfg_reg.repeat_count   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // One tick of the pulse-toggle sequencer
    rte_step #(
        .FRAME_BITS (FRAME_BITS)
    ) u_step (
        .ctl        (ctl_reg),
        .frame_word (frame_reg),
        .item       (in_data),
        .cfg        (cfg_reg),
        .ctl_next   (ctl_next),
        .frame_next (frame_next),
        .result     (result)
    );

    // Sequencer state and result register both advance on each accepted tick.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg       <= '0;
            frame_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                ctl_reg   <= ctl_next;
                frame_reg <= frame_next;
            end
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    // Result payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_accept)
            out_reg <= result;
    end

endmodule

`default_nettype wire
